// ===== hdl/sha256_pair_round_adder_diff_cost_macros.svh =====
// assertion helpers for the round adder differential block
`ifndef SHA256_PAIR_ROUND_ADDER_DIFF_COST_MACROS_SVH
`define SHA256_PAIR_ROUND_ADDER_DIFF_COST_MACROS_SVH

// implication checked every clock outside reset
`define SPR_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");

// next-cycle implication checked outside reset
`define SPR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");

`endif

// ===== hdl/spr_pkg.sv =====
package spr_pkg;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_ROUND = 1'b1;

    localparam logic [2:0] ADDER_LAST = 3'd6;

    localparam logic [31:0] LM_MASK = 32'h7FFF_FFFF;

    // one accepted beat as it travels from front to back
    typedef struct packed {
        logic        opcode;
        logic [2:0]  word_index;
        logic [31:0] load_value_first;
        logic [31:0] load_value_second;
        logic [31:0] round_constant;
        logic [31:0] word_first;
        logic [31:0] word_second;
        logic        derive_second;
    } cmd_t;

    typedef struct packed {
        logic [2:0]  adder_index;
        logic        active;
        logic [31:0] diff_alpha;
        logic [31:0] diff_beta;
        logic [31:0] diff_gamma;
        logic [5:0]  weight_alpha;
        logic [5:0]  weight_beta;
        logic [5:0]  weight_gamma;
        logic [4:0]  cost_bits;
        logic        incompatible;
        logic [5:0]  max_weight;
        logic        last;
    } rec_t;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] sig0(input logic [31:0] a);
        sig0 = rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22);
    endfunction

    function automatic logic [31:0] sig1(input logic [31:0] e);
        sig1 = rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25);
    endfunction

    function automatic logic [5:0] popcnt(input logic [31:0] x);
        logic [5:0] n;
        n = '0;
        for (int i = 0; i < 32; i++)
        begin
            n = n + {5'd0, x[i]};
        end
        popcnt = n;
    endfunction

endpackage

// ===== hdl/spr_cmd_queue.sv =====
module spr_cmd_queue
    import spr_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_data,
    output logic full,
    input  logic pop,
    output cmd_t pop_data,
    output logic empty
);
    localparam int AW = $clog2(DEPTH);

    cmd_t          mem_reg [DEPTH];
    logic [AW:0]   count_reg;
    logic [AW-1:0] wr_reg;
    logic [AW-1:0] rd_reg;
    logic          do_push;
    logic          do_pop;

    assign full     = (count_reg == (AW+1)'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            wr_reg    <= '0;
            rd_reg    <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_reg <= (wr_reg == AW'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_reg <= (rd_reg == AW'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
            end
            count_reg <= count_reg + {{AW{1'b0}}, do_push} - {{AW{1'b0}}, do_pop};
        end
    end
endmodule

// ===== hdl/spr_round_engine.sv =====
module spr_round_engine
    import spr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    input  cmd_t cmd,
    output logic cmd_take,
    output logic rec_valid,
    output rec_t rec,
    input  logic rec_take
);
    logic [31:0] p_reg [8];
    logic [31:0] q_reg [8];
    logic [2:0]  step_reg;
    logic        busy_reg;
    logic [31:0] k_reg, w1_reg, w2_reg;
    // running values of both states
    logic [31:0] x1_reg, x2_reg, t1p_reg, t1q_reg, t2p_reg, t2q_reg;
    rec_t        out_reg;
    logic        out_v_reg;

    logic [31:0] s1p, s1q, chp, chq, s0p, s0q, mjp, mjq, corr;
    logic [31:0] ap, aq, bp, bq, yp, yq;
    logic        adv;
    rec_t        r;
    logic [31:0] al, be, ga, eqv, eqs, viol;
    logic        inc, act;
    logic [5:0]  wa, wb, cw;

    assign s1p = sig1(p_reg[4]);
    assign s1q = sig1(q_reg[4]);
    assign chp = (p_reg[4] & p_reg[5]) ^ (~p_reg[4] & p_reg[6]);
    assign chq = (q_reg[4] & q_reg[5]) ^ (~q_reg[4] & q_reg[6]);
    assign s0p = sig0(p_reg[0]);
    assign s0q = sig0(q_reg[0]);
    assign mjp = (p_reg[0] & p_reg[1]) ^ (p_reg[0] & p_reg[2]) ^ (p_reg[1] & p_reg[2]);
    assign mjq = (q_reg[0] & q_reg[1]) ^ (q_reg[0] & q_reg[2]) ^ (q_reg[1] & q_reg[2]);
    assign corr = (p_reg[7] - q_reg[7]) + (s1p - s1q) + (chp - chq)
                + (s0p + mjp) - (s0q + mjq);

    assign adv = !out_v_reg || rec_take;
    assign cmd_take = cmd_valid && !busy_reg && (cmd.opcode == OP_LOAD || adv);

    always_comb
    begin
        ap = x1_reg; aq = x2_reg; bp = '0; bq = '0;
        unique case (step_reg)
            3'd0:
            begin
                ap = p_reg[7]; aq = q_reg[7]; bp = s1p; bq = s1q;
            end
            3'd1:
            begin
                bp = chp; bq = chq;
            end
            3'd2:
            begin
                bp = k_reg; bq = k_reg;
            end
            3'd3:
            begin
                bp = w1_reg; bq = w2_reg;
            end
            3'd4:
            begin
                ap = s0p; aq = s0q; bp = mjp; bq = mjq;
            end
            3'd5:
            begin
                ap = t1p_reg; aq = t1q_reg; bp = t2p_reg; bq = t2q_reg;
            end
            3'd6:
            begin
                ap = p_reg[3]; aq = q_reg[3]; bp = t1p_reg; bq = t1q_reg;
            end
            default:
            begin
                ap = x1_reg;
            end
        endcase
        yp = ap + bp;
        yq = aq + bq;
        al = ap ^ aq;
        be = bp ^ bq;
        ga = yp ^ yq;
        act = (al | be) != '0;
        eqv = ~(al ^ be) & ~(al ^ ga);
        eqs = ~((al ^ be) << 1) & ~((al ^ ga) << 1);
        viol = (al ^ be ^ ga ^ (be << 1)) & eqs;
        inc = act && (viol != '0);
        wa = popcnt(al);
        wb = popcnt(be);
        cw = popcnt(~eqv & LM_MASK);
        r.adder_index  = step_reg;
        r.active       = act;
        r.diff_alpha   = al;
        r.diff_beta    = be;
        r.diff_gamma   = ga;
        r.weight_alpha = wa;
        r.weight_beta  = wb;
        r.weight_gamma = popcnt(ga);
        r.cost_bits    = (act && !inc) ? cw[4:0] : 5'd0;
        r.incompatible = inc;
        r.max_weight   = (wa > wb) ? wa : wb;
        r.last         = (step_reg == ADDER_LAST);
    end

    assign rec_valid = out_v_reg;
    assign rec       = out_reg;

    always_ff @(posedge clk)
    begin
        if (cmd_take && cmd.opcode == OP_ROUND)
        begin
            k_reg  <= cmd.round_constant;
            w1_reg <= cmd.word_first;
            w2_reg <= cmd.derive_second ? cmd.word_first + corr : cmd.word_second;
        end
        if (busy_reg && adv)
        begin
            out_reg <= r;
            x1_reg  <= yp;
            x2_reg  <= yq;
            if (step_reg == 3'd3)
            begin
                t1p_reg <= yp; t1q_reg <= yq;
            end
            if (step_reg == 3'd4)
            begin
                t2p_reg <= yp; t2q_reg <= yq;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
            begin
                p_reg[i] <= '0;
                q_reg[i] <= '0;
            end
            step_reg  <= '0;
            busy_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            if (rec_take)
            begin
                out_v_reg <= 1'b0;
            end
            if (cmd_take && cmd.opcode == OP_LOAD)
            begin
                p_reg[cmd.word_index] <= cmd.load_value_first;
                q_reg[cmd.word_index] <= cmd.load_value_second;
            end
            else if (cmd_take)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            if (busy_reg && adv)
            begin
                out_v_reg <= 1'b1;
                if (step_reg == ADDER_LAST)
                begin
                    busy_reg <= 1'b0;
                    // shift both states one round
                    p_reg[7] <= p_reg[6]; p_reg[6] <= p_reg[5]; p_reg[5] <= p_reg[4];
                    p_reg[4] <= yp; p_reg[3] <= p_reg[2]; p_reg[2] <= p_reg[1];
                    p_reg[1] <= p_reg[0]; p_reg[0] <= t1p_reg + t2p_reg;
                    q_reg[7] <= q_reg[6]; q_reg[6] <= q_reg[5]; q_reg[5] <= q_reg[4];
                    q_reg[4] <= yq; q_reg[3] <= q_reg[2]; q_reg[2] <= q_reg[1];
                    q_reg[1] <= q_reg[0]; q_reg[0] <= t1q_reg + t2q_reg;
                end
                else
                begin
                    step_reg <= step_reg + 3'd1;
                end
            end
        end
    end
endmodule

// ===== hdl/sha256_pair_round_adder_diff_cost.sv =====
// A round beat produces seven adder records, one per cycle from a shared adder-pair datapath
// unless an unpopped record holds the result register. The engine takes beats from the queue
// only while idle, so any beat waits until the running round ends. An accepted round beat
// sets the busy and step registers before its first record is computed into the result
// register. Beats wait in a queue of QUEUE_DEPTH entries (four by default), which fills and
// raises full when records are not popped or rounds outpace the engine. The result register
// holds one record, and pop in the same cycle keeps it streaming.
module sha256_pair_round_adder_diff_cost
    import spr_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic        opcode,
    input  logic [2:0]  word_index,
    input  logic [31:0] load_value_first,
    input  logic [31:0] load_value_second,
    input  logic [31:0] round_constant,
    input  logic [31:0] word_first,
    input  logic [31:0] word_second,
    input  logic        derive_second,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  adder_index,
    output logic        active,
    output logic [31:0] diff_alpha,
    output logic [31:0] diff_beta,
    output logic [31:0] diff_gamma,
    output logic [5:0]  weight_alpha,
    output logic [5:0]  weight_beta,
    output logic [5:0]  weight_gamma,
    output logic [4:0]  cost_bits,
    output logic        incompatible,
    output logic [5:0]  max_weight,
    output logic        last
);
`include "sha256_pair_round_adder_diff_cost_macros.svh"

    cmd_t in_cmd, q_cmd;
    logic q_empty, q_take, rec_valid;
    rec_t rec;

    assign in_cmd = '{opcode, word_index, load_value_first, load_value_second,
                      round_constant, word_first, word_second, derive_second};

    spr_cmd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .clk(clk), .rst_n(rst_n), .push(push), .push_data(in_cmd), .full(full),
        .pop(q_take), .pop_data(q_cmd), .empty(q_empty)
    );

    spr_round_engine u_engine (
        .clk(clk), .rst_n(rst_n), .cmd_valid(!q_empty), .cmd(q_cmd), .cmd_take(q_take),
        .rec_valid(rec_valid), .rec(rec), .rec_take(pop && !empty)
    );

    assign empty        = !rec_valid;
    assign adder_index  = rec.adder_index;
    assign active       = rec.active;
    assign diff_alpha   = rec.diff_alpha;
    assign diff_beta    = rec.diff_beta;
    assign diff_gamma   = rec.diff_gamma;
    assign weight_alpha = rec.weight_alpha;
    assign weight_beta  = rec.weight_beta;
    assign weight_gamma = rec.weight_gamma;
    assign cost_bits    = rec.cost_bits;
    assign incompatible = rec.incompatible;
    assign max_weight   = rec.max_weight;
    assign last         = rec.last;

    `SPR_ASSERT_IMP(a_last_idx, !empty, last == (adder_index == ADDER_LAST))
    `SPR_ASSERT_IMP(a_inc_cost, !empty && incompatible, cost_bits == 5'd0 && active)
    `SPR_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(diff_gamma))
endmodule
